[src/tbo_pkg.sv]
// Shared constants and types for the triangle / box overlap pipeline.
// No dependencies.
`default_nettype none
package tbo_pkg;
	localparam int AXES = 3;
	localparam int PIPE_DEPTH = 9;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_CENTER_X = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_CENTER_Y = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_CENTER_Z = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HALF_X = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HALF_Y = CFG_IDX_BITS'(4);
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HALF_Z = CFG_IDX_BITS'(5);

	typedef struct packed {
		logic card;
		logic cross_ax;
	} sep_t;
endpackage
`default_nettype wire

[src/tbo_front.sv]
// Front stages: vertices relative to the box centre, triangle edges and the
// cardinal axis test. Depends on tbo_pkg.
`default_nettype none
module tbo_front #(
	parameter int W = 16
) (
	input  wire logic                clk,
	input  wire logic                adv,
	input  wire logic signed [W-1:0] vin [tbo_pkg::AXES][tbo_pkg::AXES],
	input  wire logic signed [W-1:0] ctr [tbo_pkg::AXES],
	input  wire logic        [W-2:0] half [tbo_pkg::AXES],
	output logic signed      [W:0]   v_s2 [tbo_pkg::AXES][tbo_pkg::AXES],
	output logic signed      [W+1:0] e_s2 [tbo_pkg::AXES][tbo_pkg::AXES],
	output logic                     card_s2
);
	import tbo_pkg::*;

	logic signed [W:0] v_s1 [AXES][AXES];
	logic card_sep;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < AXES; i++) begin
				for (int k = 0; k < AXES; k++) begin
					v_s1[i][k] <= (W+1)'(vin[i][k]) - (W+1)'(ctr[k]);
				end
			end
		end
	end

	always_comb begin
		logic signed [W+1:0] lo;
		logic signed [W+1:0] hi;
		logic signed [W+1:0] hl;
		card_sep = 1'b0;
		for (int k = 0; k < AXES; k++) begin
			lo = (W+2)'(v_s1[0][k]);
			hi = lo;
			for (int i = 1; i < AXES; i++) begin
				if ((W+2)'(v_s1[i][k]) < lo) lo = (W+2)'(v_s1[i][k]);
				if ((W+2)'(v_s1[i][k]) > hi) hi = (W+2)'(v_s1[i][k]);
			end
			hl = signed'({3'b000, half[k]});
			if (lo > hl || hi < -hl) card_sep = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s2 <= v_s1;
			card_s2 <= card_sep;
		end
	end

	for (genvar t = 0; t < AXES; t++) begin : g_edge
		localparam int T1 = (t + 1) % AXES;
		for (genvar k = 0; k < AXES; k++) begin : g_comp
			always_ff @(posedge clk) begin
				if (adv) begin
					e_s2[t][k] <= (W+2)'(v_s1[T1][k]) - (W+2)'(v_s1[t][k]);
				end
			end
		end
	end
endmodule
`default_nettype wire

[src/tbo_cross.sv]
// Separating axes from each triangle edge crossed with each box axis: products, sums, interval test.
// Depends on tbo_pkg.
`default_nettype none
module tbo_cross #(
	parameter int W = 16
) (
	input  wire logic                clk,
	input  wire logic                adv,
	input  wire logic signed [W:0]   v_s2 [tbo_pkg::AXES][tbo_pkg::AXES],
	input  wire logic signed [W+1:0] e_s2 [tbo_pkg::AXES][tbo_pkg::AXES],
	input  wire logic        [W-2:0] half [tbo_pkg::AXES],
	output logic                     sep_s5
);
	import tbo_pkg::*;

	logic [AXES*AXES-1:0] axis_sep;

	for (genvar k = 0; k < AXES; k++) begin : g_box
		localparam int J1 = (k + 1) % AXES;
		localparam int J2 = (k + 2) % AXES;
		for (genvar t = 0; t < AXES; t++) begin : g_edge
			localparam int VB = (t + 2) % AXES;
			logic signed [2*W+2:0] m_s3 [2][2];
			logic        [2*W:0]   r_s3 [2];
			logic                  nz_s3;
			logic signed [2*W+3:0] p_s4 [2];
			logic signed [2*W+3:0] rad_s4;
			logic                  nz_s4;
			logic        [W+1:0]   ae1;
			logic        [W+1:0]   ae2;

			assign ae1 = e_s2[t][J1][W+1] ? unsigned'(-e_s2[t][J1])
				: unsigned'(e_s2[t][J1]);
			assign ae2 = e_s2[t][J2][W+1] ? unsigned'(-e_s2[t][J2])
				: unsigned'(e_s2[t][J2]);

			always_ff @(posedge clk) begin
				if (adv) begin
					m_s3[0][0] <= (2*W+3)'(v_s2[t][J1]) * (2*W+3)'(e_s2[t][J2]);
					m_s3[0][1] <= (2*W+3)'(v_s2[t][J2]) * (2*W+3)'(e_s2[t][J1]);
					m_s3[1][0] <= (2*W+3)'(v_s2[VB][J1]) * (2*W+3)'(e_s2[t][J2]);
					m_s3[1][1] <= (2*W+3)'(v_s2[VB][J2]) * (2*W+3)'(e_s2[t][J1]);
					r_s3[0] <= (2*W+1)'(ae2) * (2*W+1)'(half[J1]);
					r_s3[1] <= (2*W+1)'(ae1) * (2*W+1)'(half[J2]);
					nz_s3 <= (e_s2[t][J1] != '0) || (e_s2[t][J2] != '0);
					for (int x = 0; x < 2; x++) begin
						p_s4[x] <= (2*W+4)'(m_s3[x][0]) - (2*W+4)'(m_s3[x][1]);
					end
					rad_s4 <= signed'((2*W+4)'(r_s3[0]) + (2*W+4)'(r_s3[1]));
					nz_s4 <= nz_s3;
				end
			end

			assign axis_sep[k*AXES+t] = nz_s4 &&
				((p_s4[0] > rad_s4 && p_s4[1] > rad_s4) ||
				 (p_s4[0] < -rad_s4 && p_s4[1] < -rad_s4));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sep_s5 <= |axis_sep;
		end
	end
endmodule
`default_nettype wire

[src/tbo_plane.sv]
// Triangle plane against the box: normal, split wide products, distance and
// radius sums, final compare. Depends on tbo_pkg.
`default_nettype none
module tbo_plane #(
	parameter int W = 16
) (
	input  wire logic                clk,
	input  wire logic                adv,
	input  wire logic signed [W:0]   v_s2 [tbo_pkg::AXES][tbo_pkg::AXES],
	input  wire logic signed [W+1:0] e_s2 [tbo_pkg::AXES][tbo_pkg::AXES],
	input  wire logic        [W-2:0] half [tbo_pkg::AXES],
	output logic                     sep_s9
);
	import tbo_pkg::*;

	localparam int L = W + 3;
	localparam int DW = 3 * W + 8;

	logic signed [2*W+3:0] pr_s3 [AXES][2];
	logic signed [W:0]     v0_s3 [AXES];
	logic signed [W:0]     v0_s4 [AXES];
	logic signed [W:0]     v0_s5 [AXES];
	logic signed [2*W+4:0] n_s4 [AXES];
	logic signed [2*W+4:0] n_s5 [AXES];
	logic        [2*W+4:0] an_s5 [AXES];
	logic signed [2*W+4:0] pl_s6 [AXES];
	logic signed [2*W+2:0] ph_s6 [AXES];
	logic        [2*W+1:0] ql_s6 [AXES];
	logic        [2*W:0]   qh_s6 [AXES];
	logic signed [DW-1:0]  dp_s7 [AXES];
	logic        [DW-1:0]  rp_s7 [AXES];
	logic signed [DW-1:0]  d_s8;
	logic signed [DW-1:0]  r_s8;
	logic signed [DW:0]    dr_sum;

	for (genvar k = 0; k < AXES; k++) begin : g_comp
		localparam int A = (k + 1) % AXES;
		localparam int B = (k + 2) % AXES;
		always_ff @(posedge clk) begin
			if (adv) begin
				pr_s3[k][0] <= (2*W+4)'(e_s2[0][A]) * (2*W+4)'(e_s2[1][B]);
				pr_s3[k][1] <= (2*W+4)'(e_s2[0][B]) * (2*W+4)'(e_s2[1][A]);
				v0_s3[k] <= v_s2[0][k];
				n_s4[k] <= (2*W+5)'(pr_s3[k][0]) - (2*W+5)'(pr_s3[k][1]);
				v0_s4[k] <= v0_s3[k];
				n_s5[k] <= n_s4[k];
				an_s5[k] <= n_s4[k][2*W+4] ? unsigned'(-n_s4[k]) : unsigned'(n_s4[k]);
				v0_s5[k] <= v0_s4[k];
				pl_s6[k] <= (2*W+5)'($signed({1'b0, n_s5[k][L-1:0]})) *
					(2*W+5)'(v0_s5[k]);
				ph_s6[k] <= (2*W+3)'($signed(n_s5[k][2*W+4:L])) * (2*W+3)'(v0_s5[k]);
				ql_s6[k] <= (2*W+2)'(an_s5[k][L-1:0]) * (2*W+2)'(half[k]);
				qh_s6[k] <= (2*W+1)'(an_s5[k][2*W+4:L]) * (2*W+1)'(half[k]);
				dp_s7[k] <= (DW'(ph_s6[k]) <<< L) + DW'(pl_s6[k]);
				rp_s7[k] <= (DW'(qh_s6[k]) << L) + DW'(ql_s6[k]);
			end
		end
	end

	assign dr_sum = (DW+1)'(d_s8) + (DW+1)'(r_s8);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s8 <= dp_s7[0] + dp_s7[1] + dp_s7[2];
			r_s8 <= signed'(rp_s7[0] + rp_s7[1] + rp_s7[2]);
			sep_s9 <= (d_s8 > r_s8) || dr_sum[DW];
		end
	end
endmodule
`default_nettype wire

[src/triangle_box_overlap_test_core.sv]
// Triangle / axis-aligned box overlap test, top level.
// Accepts one triangle per cycle unless an output stall holds the pipeline.
// The nine-register pipeline advances as one; an output stall while out_valid is high freezes it.
// Reset clears the box registers and all stage valid bits.
// Depends on tbo_pkg, tbo_front, tbo_cross, tbo_plane.
`default_nettype none
module triangle_box_overlap_test_core #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tbo_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [COORD_BITS-1:0]               cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [COORD_BITS-1:0]        v0_x,
	input  wire logic signed [COORD_BITS-1:0]        v0_y,
	input  wire logic signed [COORD_BITS-1:0]        v0_z,
	input  wire logic signed [COORD_BITS-1:0]        v1_x,
	input  wire logic signed [COORD_BITS-1:0]        v1_y,
	input  wire logic signed [COORD_BITS-1:0]        v1_z,
	input  wire logic signed [COORD_BITS-1:0]        v2_x,
	input  wire logic signed [COORD_BITS-1:0]        v2_y,
	input  wire logic signed [COORD_BITS-1:0]        v2_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     overlap
);
	import tbo_pkg::*;

	localparam int W = COORD_BITS;

	logic signed [W-1:0] ctr_q [AXES];
	logic        [W-2:0] half_q [AXES];
	logic signed [W-1:0] vin [AXES][AXES];
	logic signed [W:0]   v_s2 [AXES][AXES];
	logic signed [W+1:0] e_s2 [AXES][AXES];
	logic                card_s2;
	logic                card_s3;
	logic                card_s4;
	logic                card_s5;
	logic                cross_s5;
	logic                plane_s9;
	sep_t                flg_s6;
	sep_t                flg_s7;
	sep_t                flg_s8;
	sep_t                flg_s9;
	logic [PIPE_DEPTH-1:0] stage_valid_q;
	logic                adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXES; k++) begin
				ctr_q[k] <= '0;
				half_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_CENTER_X: ctr_q[0] <= cfg_data;
				REG_BOX_CENTER_Y: ctr_q[1] <= cfg_data;
				REG_BOX_CENTER_Z: ctr_q[2] <= cfg_data;
				REG_BOX_HALF_X:   half_q[0] <= cfg_data[W-2:0];
				REG_BOX_HALF_Y:   half_q[1] <= cfg_data[W-2:0];
				REG_BOX_HALF_Z:   half_q[2] <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	assign vin[0][0] = v0_x;
	assign vin[0][1] = v0_y;
	assign vin[0][2] = v0_z;
	assign vin[1][0] = v1_x;
	assign vin[1][1] = v1_y;
	assign vin[1][2] = v1_z;
	assign vin[2][0] = v2_x;
	assign vin[2][1] = v2_y;
	assign vin[2][2] = v2_z;

	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else if (adv) begin
			stage_valid_q <= {stage_valid_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	tbo_front #(.W(W)) u_front (
		.clk(clk), .adv(adv), .vin(vin), .ctr(ctr_q), .half(half_q),
		.v_s2(v_s2), .e_s2(e_s2), .card_s2(card_s2)
	);

	tbo_cross #(.W(W)) u_cross (
		.clk(clk), .adv(adv), .v_s2(v_s2), .e_s2(e_s2), .half(half_q),
		.sep_s5(cross_s5)
	);

	tbo_plane #(.W(W)) u_plane (
		.clk(clk), .adv(adv), .v_s2(v_s2), .e_s2(e_s2), .half(half_q),
		.sep_s9(plane_s9)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			card_s3 <= card_s2;
			card_s4 <= card_s3;
			card_s5 <= card_s4;
			flg_s6 <= '{card: card_s5, cross_ax: cross_s5};
			flg_s7 <= flg_s6;
			flg_s8 <= flg_s7;
			flg_s9 <= flg_s8;
		end
	end

	assign out_valid = stage_valid_q[PIPE_DEPTH-1];
	assign overlap = !(flg_s9.card || flg_s9.cross_ax || plane_s9);

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(stage_valid_q))
		else $error("pipeline moved during output stall");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> stage_valid_q[0])
		else $error("input transfer lost at first stage");
endmodule
`default_nettype wire

[tb/triangle_box_overlap_test_core_tb.sv]
// Testbench for triangle_box_overlap_test_core: drives triangles against a configured box
// and checks each overlap result against an exact separating-axis predictor.
// Depends on tbo_pkg and the core RTL.
`default_nettype none
module triangle_box_overlap_test_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tbo_pkg::*;

	localparam int CB = 16;

	typedef logic signed [CB-1:0] coord_t;
	typedef struct {
		coord_t c [3];
	} vert_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CB-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t v0_x = '0, v0_y = '0, v0_z = '0;
	coord_t v1_x = '0, v1_y = '0, v1_z = '0;
	coord_t v2_x = '0, v2_y = '0, v2_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic overlap;

	triangle_box_overlap_test_core #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
		.v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
		.out_valid(out_valid), .out_stall(out_stall), .overlap(overlap)
	);

	always #6 clk = ~clk;

	longint box_ctr [3];
	longint box_half [3];
	logic expected_overlap [$];
	int fail_count = 0;
	bit idle_on = 1'b1;

	function automatic logic predict_overlap(vert_t tri_v [3]);
		longint v [3][3];
		longint e [3][3];
		longint n [3];
		longint a [3];
		longint lo, hi, p, rad, dd, rr;
		v = '{default: 0};
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				v[i][k] = longint'(tri_v[i].c[k]) - box_ctr[k];
		for (int k = 0; k < 3; k++) begin
			lo = v[0][k];
			hi = v[0][k];
			for (int i = 1; i < 3; i++) begin
				if (v[i][k] < lo) lo = v[i][k];
				if (v[i][k] > hi) hi = v[i][k];
			end
			if (lo > box_half[k] || hi < -box_half[k])
				return 1'b0;
		end
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				e[i][k] = v[(i + 1) % 3][k] - v[i][k];
		n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
		n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
		n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
		dd = 0;
		rr = 0;
		for (int k = 0; k < 3; k++) begin
			dd += n[k] * v[0][k];
			rr += (n[k] < 0 ? -n[k] : n[k]) * box_half[k];
		end
		if (rr < dd || dd < -rr)
			return 1'b0;
		for (int k = 0; k < 3; k++)
			for (int t = 0; t < 3; t++) begin
				a[0] = (k == 2) ? e[t][1] : (k == 1) ? -e[t][2] : 0;
				a[1] = (k == 0) ? e[t][2] : (k == 2) ? -e[t][0] : 0;
				a[2] = (k == 1) ? e[t][0] : (k == 0) ? -e[t][1] : 0;
				if (a[0] == 0 && a[1] == 0 && a[2] == 0)
					continue;
				for (int i = 0; i < 3; i++) begin
					p = v[i][0] * a[0] + v[i][1] * a[1] + v[i][2] * a[2];
					if (i == 0 || p < lo) lo = p;
					if (i == 0 || p > hi) hi = p;
				end
				rad = 0;
				for (int j = 0; j < 3; j++)
					rad += (a[j] < 0 ? -a[j] : a[j]) * box_half[j];
				if (lo > rad || hi < -rad)
					return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic bit idle_roll();
		return idle_on && ($urandom_range(99) < 31);
	endfunction

	task automatic write_box_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_BOX_CENTER_X: box_ctr[0] = longint'(signed'(val));
			REG_BOX_CENTER_Y: box_ctr[1] = longint'(signed'(val));
			REG_BOX_CENTER_Z: box_ctr[2] = longint'(signed'(val));
			REG_BOX_HALF_X: box_half[0] = longint'(val[CB-2:0]);
			REG_BOX_HALF_Y: box_half[1] = longint'(val[CB-2:0]);
			REG_BOX_HALF_Z: box_half[2] = longint'(val[CB-2:0]);
			default: ;
		endcase
	endtask

	task automatic drain_pipe();
		int guard;
		guard = 0;
		while (expected_overlap.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	task automatic set_box(longint cx, longint cy, longint cz, longint hx, longint hy,
			longint hz);
		drain_pipe();
		write_box_reg(REG_BOX_CENTER_X, CB'(cx));
		write_box_reg(REG_BOX_CENTER_Y, CB'(cy));
		write_box_reg(REG_BOX_CENTER_Z, CB'(cz));
		write_box_reg(REG_BOX_HALF_X, CB'(hx));
		write_box_reg(REG_BOX_HALF_Y, CB'(hy));
		write_box_reg(REG_BOX_HALF_Z, CB'(hz));
	endtask

	task automatic send_triangle(vert_t tri_v [3]);
		while (idle_roll()) @(negedge clk);
		{v0_x, v0_y, v0_z} = {tri_v[0].c[0], tri_v[0].c[1], tri_v[0].c[2]};
		{v1_x, v1_y, v1_z} = {tri_v[1].c[0], tri_v[1].c[1], tri_v[1].c[2]};
		{v2_x, v2_y, v2_z} = {tri_v[2].c[0], tri_v[2].c[1], tri_v[2].c[2]};
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_overlap.push_back(predict_overlap(tri_v));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic vert_t mk_vert(longint x, longint y, longint z);
		vert_t r;
		r.c[0] = coord_t'(x);
		r.c[1] = coord_t'(y);
		r.c[2] = coord_t'(z);
		return r;
	endfunction

	function automatic longint near_coord(longint ctr, longint span);
		longint r;
		r = ctr + longint'($urandom_range(2 * span)) - span;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	task automatic test_extremes();
		vert_t t [3];
		set_box(0, 0, 0, 0, 0, 0);
		t = '{mk_vert(0, 0, 0), mk_vert(0, 0, 0), mk_vert(0, 0, 0)};
		send_triangle(t);
		t = '{mk_vert(-32768, -32768, -32768), mk_vert(32767, 32767, 32767),
			mk_vert(32767, -32768, 0)};
		send_triangle(t);
		t = '{mk_vert(1, 1, 1), mk_vert(2, 2, 2), mk_vert(3, 3, 3)};
		send_triangle(t);
		set_box(32767, -32768, 32767, 32767, 32767, 32767);
		t = '{mk_vert(-32768, 32767, -32768), mk_vert(32767, -32768, 32767),
			mk_vert(-32768, -32768, 32767)};
		send_triangle(t);
		t = '{mk_vert(-32768, 32767, -32768), mk_vert(-32768, 32767, -32768),
			mk_vert(-32768, 32767, -32767)};
		send_triangle(t);
		set_box(-32768, 32767, -32768, 0, 32767, 0);
		t = '{mk_vert(-32768, 0, -32768), mk_vert(-32768, 100, -32768),
			mk_vert(-32767, 0, -32768)};
		send_triangle(t);
		set_box(0, 0, 0, 10, 10, 10);
		// touching faces, a face miss, slanted planes cutting or touching a corner and thin slanted triangles
		t = '{mk_vert(10, 0, 0), mk_vert(20, 0, 0), mk_vert(20, 5, 5)};
		send_triangle(t);
		t = '{mk_vert(11, 0, 0), mk_vert(20, 0, 0), mk_vert(20, 5, 5)};
		send_triangle(t);
		t = '{mk_vert(25, 0, 0), mk_vert(0, 25, 0), mk_vert(0, 0, 25)};
		send_triangle(t);
		t = '{mk_vert(30, 0, 0), mk_vert(0, 30, 0), mk_vert(0, 0, 30)};
		send_triangle(t);
		t = '{mk_vert(-15, 12, 0), mk_vert(12, -15, 0), mk_vert(12, -15, 3)};
		send_triangle(t);
		t = '{mk_vert(-9, 12, 0), mk_vert(12, -9, 0), mk_vert(12, -9, 3)};
		send_triangle(t);
		// writes to unused register indices must be ignored; half-x then gets an all-ones write
		drain_pipe();
		write_box_reg(CFG_IDX_BITS'(6), 16'h1234);
		write_box_reg(CFG_IDX_BITS'(7), 16'hFFFF);
		write_box_reg(REG_BOX_HALF_X, 16'hFFFF);
		t = '{mk_vert(32767, 0, 0), mk_vert(-32768, 0, 0), mk_vert(0, 1, 1)};
		send_triangle(t);
	endtask

	task automatic test_random(int count);
		vert_t t [3];
		longint ctr [3];
		longint span;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				idle_on = (n % 300 != 200);
				for (int k = 0; k < 3; k++) ctr[k] = longint'(signed'(16'($urandom)));
				set_box(ctr[0], ctr[1], ctr[2], $urandom_range(32767) >> $urandom_range(14),
					$urandom_range(32767) >> $urandom_range(14),
					$urandom_range(32767) >> $urandom_range(14));
			end
			case ($urandom_range(3))
				0: span = 32768;
				1: span = 2000;
				default: span = box_half[$urandom_range(2)] + 64;
			endcase
			for (int i = 0; i < 3; i++)
				if ($urandom_range(9) == 0)
					t[i] = mk_vert(signed'(16'($urandom)), signed'(16'($urandom)),
						signed'(16'($urandom)));
				else
					t[i] = mk_vert(near_coord(box_ctr[0], span), near_coord(box_ctr[1], span),
						near_coord(box_ctr[2], span));
			send_triangle(t);
		end
		idle_on = 1'b1;
	endtask

	always @(negedge clk)
		out_stall <= idle_roll();

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_overlap.size() == 0) begin
				$error("overlap: unexpected transfer, actual %0b", overlap);
				fail_count++;
			end else begin
				logic want;
				want = expected_overlap.pop_front();
				if (overlap !== want) begin
					$error("overlap: expected %0b actual %0b", want, overlap);
					fail_count++;
				end
			end
		end
	end

	initial begin
		box_ctr = '{0, 0, 0};
		box_half = '{0, 0, 0};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_random(1000);
		drain_pipe();
		if (fail_count == 0 && expected_overlap.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
